FILE: rtl/vbcs_pkg.sv
// shared constants, types and helper functions of the breath cycle sequencer
package vbcs_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TIMER_BITS  = 16;

  localparam int MODE_W  = 1;
  localparam int LEVEL_W = 11;
  localparam int MS_W    = 16;
  localparam int TIDAL_W = 12;
  localparam int FLOW_W  = 11;
  localparam int MIX_W   = 7;
  localparam int PHASE_W = 3;

  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int APB_ADDR_W = REG_IDX_W + 2;
  localparam int APB_DATA_W = 32;

  localparam logic [TIMER_BITS-1:0] TMAX = '1;
  localparam logic [MIX_W-1:0]      MIX_FULL = MIX_W'(100);

  // inspiratory time = 600 * volume / flow, 6 times 100
  localparam int INSP_SCALE = 6 * 100;
  localparam int SCALE_W    = $clog2(INSP_SCALE + 1);
  localparam int DIV_NUM_W  = TIDAL_W + SCALE_W;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

  // signed compare width for a sample against an unsigned level
  localparam int CMP_W = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;

  localparam int SAT_MS_W = (MS_W > TIMER_BITS) ? MS_W : TIMER_BITS;
  localparam int SAT_Q_W  = (DIV_NUM_W > TIMER_BITS) ? DIV_NUM_W : TIMER_BITS;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_PLIMIT    = 3'd1,
    REG_PEEP      = 3'd2,
    REG_HOLD      = 3'd3,
    REG_PAUSE     = 3'd4,
    REG_TIDAL     = 3'd5,
    REG_FLOW      = 3'd6,
    REG_MIX_STEP  = 3'd7
  } reg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_FILL   = 5'b00010,
    PH_HOLD   = 5'b00100,
    PH_EXHALE = 5'b01000,
    PH_PAUSE  = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    CTL_RUN = 2'b01,
    CTL_DIV = 2'b10
  } ctl_e;

  localparam logic [PHASE_W-1:0] CODE_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] CODE_FILL   = 3'd1;
  localparam logic [PHASE_W-1:0] CODE_HOLD   = 3'd2;
  localparam logic [PHASE_W-1:0] CODE_EXHALE = 3'd3;
  localparam logic [PHASE_W-1:0] CODE_PAUSE  = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  breathing_mode;
    logic [LEVEL_W-1:0] pressure_limit;
    logic [LEVEL_W-1:0] peep_level;
    logic [MS_W-1:0]    inspire_hold_ms;
    logic [MS_W-1:0]    expire_pause_ms;
    logic [TIDAL_W-1:0] tidal_volume_ml;
    logic [FLOW_W-1:0]  target_flow;
    logic [MIX_W-1:0]   mix_step;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [FLOW_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [TIMER_BITS-1:0] sat_ms(input logic [MS_W-1:0] v);
    logic [SAT_MS_W-1:0] x;
    x = SAT_MS_W'(v);
    if (x > SAT_MS_W'(TMAX)) return TMAX;
    return TIMER_BITS'(x);
  endfunction

  function automatic logic [TIMER_BITS-1:0] sat_quot(input logic [DIV_NUM_W-1:0] v);
    logic [SAT_Q_W-1:0] x;
    x = SAT_Q_W'(v);
    if (x > SAT_Q_W'(TMAX)) return TMAX;
    return TIMER_BITS'(x);
  endfunction

  function automatic logic [PHASE_W-1:0] phase_code(input phase_e ph);
    case (ph)
      PH_FILL:   return CODE_FILL;
      PH_HOLD:   return CODE_HOLD;
      PH_EXHALE: return CODE_EXHALE;
      PH_PAUSE:  return CODE_PAUSE;
      default:   return CODE_IDLE;
    endcase
  endfunction

endpackage

FILE: rtl/vbcs_if.sv
// tick and result channel interfaces
interface vbcs_tick_if;
  import vbcs_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          started;
  logic signed [SAMPLE_BITS-1:0] pressure;
  logic signed [SAMPLE_BITS-1:0] flow;
  modport source (output valid, started, pressure, flow, input ready);
  modport sink   (input valid, started, pressure, flow, output ready);
endinterface

interface vbcs_result_if;
  import vbcs_pkg::*;
  logic               valid;
  logic               ready;
  logic               solenoid_open;
  logic               membrane_open;
  logic [MIX_W-1:0]   mix_percent;
  logic [PHASE_W-1:0] phase;
  modport source (output valid, solenoid_open, membrane_open, mix_percent, phase,
                  input ready);
  modport sink   (input valid, solenoid_open, membrane_open, mix_percent, phase,
                  output ready);
endinterface

FILE: rtl/vbcs_cfg.sv
// apb register bank holding the breath settings
module vbcs_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vbcs_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [vbcs_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [vbcs_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output vbcs_pkg::cfg_t                       cfg_o
);
  import vbcs_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.breathing_mode  <= '0;
      cfg_q.pressure_limit  <= LEVEL_W'(200);
      cfg_q.peep_level      <= LEVEL_W'(50);
      cfg_q.inspire_hold_ms <= MS_W'(2000);
      cfg_q.expire_pause_ms <= MS_W'(3000);
      cfg_q.tidal_volume_ml <= TIDAL_W'(300);
      cfg_q.target_flow     <= FLOW_W'(150);
      cfg_q.mix_step        <= MIX_W'(1);
    end else if (wr_en) begin
      case (idx)
        REG_MODE:     cfg_q.breathing_mode  <= pwdata[MODE_W-1:0];
        REG_PLIMIT:   cfg_q.pressure_limit  <= pwdata[LEVEL_W-1:0];
        REG_PEEP:     cfg_q.peep_level      <= pwdata[LEVEL_W-1:0];
        REG_HOLD:     cfg_q.inspire_hold_ms <= pwdata[MS_W-1:0];
        REG_PAUSE:    cfg_q.expire_pause_ms <= pwdata[MS_W-1:0];
        REG_TIDAL:    cfg_q.tidal_volume_ml <= pwdata[TIDAL_W-1:0];
        REG_FLOW:     cfg_q.target_flow     <= pwdata[FLOW_W-1:0];
        REG_MIX_STEP: cfg_q.mix_step        <= pwdata[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:     prdata = APB_DATA_W'(cfg_q.breathing_mode);
      REG_PLIMIT:   prdata = APB_DATA_W'(cfg_q.pressure_limit);
      REG_PEEP:     prdata = APB_DATA_W'(cfg_q.peep_level);
      REG_HOLD:     prdata = APB_DATA_W'(cfg_q.inspire_hold_ms);
      REG_PAUSE:    prdata = APB_DATA_W'(cfg_q.expire_pause_ms);
      REG_TIDAL:    prdata = APB_DATA_W'(cfg_q.tidal_volume_ml);
      REG_FLOW:     prdata = APB_DATA_W'(cfg_q.target_flow);
      REG_MIX_STEP: prdata = APB_DATA_W'(cfg_q.mix_step);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: rtl/vbcs_div.sv
// shared restoring divider, one quotient bit per cycle
module vbcs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vbcs_pkg::div_req_t req_i,
  output vbcs_pkg::div_rsp_t rsp_o
);
  import vbcs_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [FLOW_W-1:0]    rem_q, rem_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [FLOW_W-1:0]    div_q, div_d;
  logic [FLOW_W:0]      trial;
  logic                 fits;

  // dividend bits shift out of the top of quo_q while quotient bits enter below
  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    div_d = div_q;
    if (req_i.start) begin
      cnt_d = DIV_CNT_W'(DIV_NUM_W);
      rem_d = '0;
      quo_d = req_i.dividend;
      div_d = req_i.divisor;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      // a zero divisor always fits, giving an all-ones quotient that saturates
      rem_d = fits ? FLOW_W'(trial - {1'b0, div_q}) : trial[FLOW_W-1:0];
      quo_d = {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.busy     = cnt_q != '0;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/ventilator_breath_cycle_sequencer.sv
// breath cycle sequencer top level: tick channel, result channel, apb settings
//
// usage notes
// - in_i carries one 1 ms tick per transaction: run switch, pressure and flow
//   samples. out_o returns exactly one result per tick: solenoid, membrane,
//   mix valve percent and phase code.
// - a tick's result is registered on the edge that accepts the tick, so the
//   result can be taken in the cycle after acceptance.
// - a tick that starts a breath from idle also launches the shared divider
//   for the inspiratory time; it runs one quotient bit a cycle, the quotient
//   is then loaded into the inspiratory time, and in_i.ready stays low until
//   that load. only such a tick holds in_i.ready low for the divider.
// - one result register sits on the output; a new tick is taken while it is
//   empty or being drained in the same cycle. if the receiver stalls, the
//   result holds and in_i.ready drops.
// - settings are written through the apb port while no tick is in flight;
//   reads return the stored value, pready is tied high.
// - reset puts the cycle in idle with all timers, mix level and inspiratory
//   time cleared and loads the default settings.
module ventilator_breath_cycle_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  vbcs_tick_if.sink                       in_i,
  vbcs_result_if.source                   out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vbcs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vbcs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vbcs_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import vbcs_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  vbcs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vbcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ctl_e                   ctl_q, ctl_d;
  phase_e                 phase_q, phase_d;
  logic [TIMER_BITS-1:0]  timer_q, timer_d;
  logic [TIMER_BITS-1:0]  fill_q, fill_d;
  logic [MIX_W-1:0]       mix_q, mix_d;
  logic                   ramp_q, ramp_d;
  logic [TIMER_BITS-1:0]  insp_q, insp_d;
  logic                   oval_q, oval_d;

  logic                   out_sol_q, out_mem_q;
  logic [MIX_W-1:0]       out_mix_q;
  logic [PHASE_W-1:0]     out_phase_q;
  logic                   res_sol, res_mem;
  logic [MIX_W-1:0]       res_mix;

  logic                   in_acc, out_acc, vol;
  logic signed [CMP_W-1:0] press_x, flow_x, limit_x, peep_x, tflow_x;
  logic                   fill_go;
  logic [TIMER_BITS-1:0]  fill_inc, half;
  logic [MIX_W:0]         mix_sum;

  assign in_i.ready = (ctl_q == CTL_RUN) && (!oval_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign vol        = cfg.breathing_mode[0];

  assign press_x = CMP_W'(in_i.pressure);
  assign flow_x  = CMP_W'(in_i.flow);
  assign limit_x = signed'(CMP_W'(cfg.pressure_limit));
  assign peep_x  = signed'(CMP_W'(cfg.peep_level));
  assign tflow_x = signed'(CMP_W'(cfg.target_flow));

  assign fill_go  = (press_x < limit_x) && !(vol && (flow_x >= tflow_x));
  assign fill_inc = (fill_q != TMAX) ? fill_q + 1'b1 : fill_q;
  assign half     = fill_inc >> 1;
  assign mix_sum  = {1'b0, mix_q} + {1'b0, cfg.mix_step};

  assign div_req.start    = in_acc && (phase_q == PH_IDLE) && in_i.started;
  assign div_req.dividend = DIV_NUM_W'(cfg.tidal_volume_ml) * DIV_NUM_W'(INSP_SCALE);
  assign div_req.divisor  = cfg.target_flow;

  // one tick of the breath cycle
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    fill_d  = fill_q;
    mix_d   = mix_q;
    ramp_d  = ramp_q;
    case (phase_q)
      PH_IDLE: begin
        if (in_i.started) begin
          mix_d   = '0;
          ramp_d  = 1'b0;
          fill_d  = '0;
          phase_d = PH_FILL;
        end
      end
      PH_FILL: begin
        fill_d = fill_inc;
        if (fill_go) begin
          if (!ramp_q) begin
            mix_d = (mix_sum > {1'b0, MIX_FULL}) ? MIX_FULL : mix_sum[MIX_W-1:0];
          end
        end else begin
          ramp_d  = 1'b1;
          phase_d = PH_HOLD;
          if (vol) begin
            timer_d = (insp_q >= half) ? insp_q - half : half - insp_q;
          end else begin
            timer_d = sat_ms(cfg.inspire_hold_ms);
          end
        end
      end
      PH_HOLD: begin
        if (timer_q <= TIMER_BITS'(1) || (vol && press_x >= limit_x)) begin
          phase_d = PH_EXHALE;
        end else begin
          timer_d = timer_q - 1'b1;
        end
      end
      PH_EXHALE: begin
        if (!(press_x > peep_x)) begin
          timer_d = sat_ms(cfg.expire_pause_ms);
          phase_d = PH_PAUSE;
        end
      end
      PH_PAUSE: begin
        if (timer_q <= TIMER_BITS'(1)) begin
          if (in_i.started) begin
            fill_d  = '0;
            phase_d = PH_FILL;
          end else begin
            phase_d = PH_IDLE;
          end
        end else begin
          timer_d = timer_q - 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    case (phase_d)
      PH_FILL:   begin res_sol = 1'b1; res_mem = 1'b0; res_mix = mix_d; end
      PH_HOLD:   begin res_sol = vol;  res_mem = 1'b0; res_mix = mix_d; end
      PH_EXHALE: begin res_sol = 1'b0; res_mem = 1'b1; res_mix = mix_d; end
      PH_PAUSE:  begin res_sol = 1'b0; res_mem = 1'b0; res_mix = mix_d; end
      default:   begin res_sol = 1'b0; res_mem = 1'b1; res_mix = '0;    end
    endcase
  end

  always_comb begin
    ctl_d  = ctl_q;
    insp_d = insp_q;
    case (ctl_q)
      CTL_RUN: if (div_req.start) ctl_d = CTL_DIV;
      CTL_DIV: begin
        if (!div_rsp.busy) begin
          insp_d = sat_quot(div_rsp.quotient);
          ctl_d  = CTL_RUN;
        end
      end
      default: ctl_d = CTL_RUN;
    endcase
    oval_d = in_acc ? 1'b1 : (out_acc ? 1'b0 : oval_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= CTL_RUN;
      phase_q <= PH_IDLE;
      timer_q <= '0;
      fill_q  <= '0;
      mix_q   <= '0;
      ramp_q  <= 1'b0;
      insp_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      ctl_q  <= ctl_d;
      insp_q <= insp_d;
      oval_q <= oval_d;
      if (in_acc) begin
        phase_q <= phase_d;
        timer_q <= timer_d;
        fill_q  <= fill_d;
        mix_q   <= mix_d;
        ramp_q  <= ramp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_sol_q   <= res_sol;
      out_mem_q   <= res_mem;
      out_mix_q   <= res_mix;
      out_phase_q <= phase_code(phase_d);
    end
  end

  assign out_o.valid         = oval_q;
  assign out_o.solenoid_open = out_sol_q;
  assign out_o.membrane_open = out_mem_q;
  assign out_o.mix_percent   = out_mix_q;
  assign out_o.phase         = out_phase_q;

  a_div_blocks_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> !in_i.ready)
    else $error("tick taken while divider busy");

  a_start_runs_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_IDLE && in_i.started) |=> (div_rsp.busy && ctl_q == CTL_DIV))
    else $error("breath start did not launch divider");

  a_mix_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_q <= MIX_FULL)
    else $error("mix level above full");

  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.phase == CODE_IDLE) |->
      (out_o.mix_percent == '0 && out_o.membrane_open && !out_o.solenoid_open))
    else $error("idle result drives valves");

endmodule
